/* sv/gtf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtf_pkg
// Shared types and constants for the gravity torque feed-forward core.
// ---------------------------------------------------------------------------
package gtf_pkg;

  typedef struct packed {
    logic [15:0] angle_shoulder;
    logic [15:0] angle_elbow;
    logic [15:0] angle_wrist;
  } gtf_in_t;

  typedef struct packed {
    logic signed [31:0] torque_shoulder;
    logic signed [31:0] torque_elbow;
    logic signed [31:0] torque_wrist;
  } gtf_out_t;

  localparam logic [2:0] REG_SIN_A = 3'd0;
  localparam logic [2:0] REG_COS_A = 3'd1;
  localparam logic [2:0] REG_SIN_B = 3'd2;
  localparam logic [2:0] REG_COS_B = 3'd3;
  localparam logic [2:0] REG_SIN_C = 3'd4;
  localparam logic [2:0] REG_COS_C = 3'd5;

  // Taylor coefficients of sin(pi*x/2), Q30
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598669;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026994;
  localparam logic [31:0] K9 = 32'd172272;

endpackage

/* sv/gtf_trig_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtf_trig_lane
// Pipelined sine and cosine of one binary angle, Q1.15.
// ---------------------------------------------------------------------------
module gtf_trig_lane
  import gtf_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                     clk,
  input  logic [ANGLE_BITS-1:0]    angle,
  output logic signed [15:0]       sin_q15,
  output logic signed [15:0]       cos_q15
);

  localparam int RB = ANGLE_BITS - 2;
  localparam logic [RB:0] QUARTER = {1'b1, {RB{1'b0}}};

  // both evaluations run as two sub-lanes: index 0 sine, 1 cosine
  logic [ANGLE_BITS-1:0] ang [2];
  assign ang[0] = angle;
  assign ang[1] = angle + ANGLE_BITS'(QUARTER);

  logic [1:0]  q_s0 [2];
  logic [31:0] x_s0 [2];
  logic [1:0]  q_s1 [2], q_s2 [2], q_s3 [2], q_s4 [2], q_s5 [2], q_s6 [2];
  logic [31:0] x_s1 [2], x_s2 [2], x_s3 [2], x_s4 [2], x_s5 [2];
  logic [31:0] z_s1 [2], z_s2 [2], z_s3 [2], z_s4 [2];
  logic [31:0] p_s2 [2], p_s3 [2], p_s4 [2], p_s5 [2];
  logic [15:0] m_s6 [2];

  for (genvar k = 0; k < 2; k++) begin : g_sc
    logic [RB:0]  r;
    logic [63:0]  zz, pz, xs;
    logic [32:0]  xw;
    logic [16:0]  sr;

    always_comb begin
      if (ang[k][RB]) begin
        r = QUARTER - {1'b0, ang[k][RB-1:0]};
      end else begin
        r = {1'b0, ang[k][RB-1:0]};
      end
      xw = 33'(r) << (32 - ANGLE_BITS);
    end

    always_ff @(posedge clk) begin
      // x <= 2^30, fits 32 bits
      x_s0[k] <= xw[31:0];
      q_s0[k] <= ang[k][ANGLE_BITS-1:ANGLE_BITS-2];
    end

    assign zz = x_s0[k] * x_s0[k];
    always_ff @(posedge clk) begin
      z_s1[k] <= 32'(zz >> 30);
      x_s1[k] <= x_s0[k];
      q_s1[k] <= q_s0[k];
    end

    always_ff @(posedge clk) begin
      p_s2[k] <= K7 - 32'((64'(z_s1[k]) * 64'(K9)) >> 30);
      z_s2[k] <= z_s1[k];
      x_s2[k] <= x_s1[k];
      q_s2[k] <= q_s1[k];
    end
    always_ff @(posedge clk) begin
      p_s3[k] <= K5 - 32'((64'(z_s2[k]) * 64'(p_s2[k])) >> 30);
      z_s3[k] <= z_s2[k];
      x_s3[k] <= x_s2[k];
      q_s3[k] <= q_s2[k];
    end
    always_ff @(posedge clk) begin
      p_s4[k] <= K3 - 32'((64'(z_s3[k]) * 64'(p_s3[k])) >> 30);
      z_s4[k] <= z_s3[k];
      x_s4[k] <= x_s3[k];
      q_s4[k] <= q_s3[k];
    end
    assign pz = z_s4[k] * p_s4[k];
    always_ff @(posedge clk) begin
      p_s5[k] <= K1 - 32'(pz >> 30);
      x_s5[k] <= x_s4[k];
      q_s5[k] <= q_s4[k];
    end
    assign xs = x_s5[k] * p_s5[k];
    assign sr = 17'(((xs >> 30) + 64'd16384) >> 15);
    always_ff @(posedge clk) begin
      m_s6[k] <= (sr > 17'd32767) ? 16'd32767 : sr[15:0];
      q_s6[k] <= q_s5[k];
    end
  end

  assign sin_q15 = q_s6[0][1] ? -$signed(m_s6[0]) : $signed(m_s6[0]);
  assign cos_q15 = q_s6[1][1] ? -$signed(m_s6[1]) : $signed(m_s6[1]);

endmodule

/* sv/gtf_merge.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtf_merge
// Weights the trig terms of the three lanes and forms nested torque sums.
// ---------------------------------------------------------------------------
module gtf_merge
  import gtf_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] trig  [6],
  input  logic signed [31:0] gain  [6],
  output gtf_out_t           torque
);

  logic signed [47:0] prod [6];
  logic signed [49:0] tc, tb, ta;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod[i] <= gain[i] * trig[i];
    end
  end

  always_ff @(posedge clk) begin
    tc <= 50'(prod[4]) + 50'(prod[5]);
    tb <= 50'(prod[2]) + 50'(prod[3]) + 50'(prod[4]) + 50'(prod[5]);
    ta <= 50'(prod[0]) + 50'(prod[1]) + 50'(prod[2]) + 50'(prod[3])
        + 50'(prod[4]) + 50'(prod[5]);
  end

  function automatic logic signed [31:0] to_q16(input logic signed [49:0] v);
    logic signed [49:0] t;
    logic signed [34:0] q;
    t = v + 50'sd16384;
    q = 35'(t >>> 15);
    if (q > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (q < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  always_ff @(posedge clk) begin
    torque.torque_shoulder <= to_q16(ta);
    torque.torque_elbow    <= to_q16(tb);
    torque.torque_wrist    <= to_q16(tc);
  end

endmodule

/* sv/gravity_torque_feedforward_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gravity_torque_feedforward_core
// One item per cycle, fully pipelined.
// Three trig lanes (one per cumulative angle) feed one merge unit.
// Start reaches done through the angle register, the 7-stage Horner pipeline and 3 merge stages.
// Reset clears the gains and the valid pipeline; results cannot be stalled.
// ---------------------------------------------------------------------------
module gravity_torque_feedforward_core
  import gtf_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  gtf_in_t     in_item,
  output logic        done,
  output gtf_out_t    result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LAT = 11;

  logic signed [31:0] gain [6];
  logic [LAT-1:0] vld;
  logic [ANGLE_BITS-1:0] a, b, c, ang_r [3];
  logic signed [15:0] trig [6];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) gain[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIN_A: gain[0] <= cfg_data;
        REG_COS_A: gain[1] <= cfg_data;
        REG_SIN_B: gain[2] <= cfg_data;
        REG_COS_B: gain[3] <= cfg_data;
        REG_SIN_C: gain[4] <= cfg_data;
        REG_COS_C: gain[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end
  assign done = vld[LAT-1];

  assign a = ANGLE_BITS'(in_item.angle_shoulder);
  assign b = a + ANGLE_BITS'(in_item.angle_elbow);
  assign c = b + ANGLE_BITS'(in_item.angle_wrist);

  always_ff @(posedge clk) begin
    ang_r[0] <= a;
    ang_r[1] <= b;
    ang_r[2] <= c;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    gtf_trig_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane (
      .clk     (clk),
      .angle   (ang_r[l]),
      .sin_q15 (trig[2*l]),
      .cos_q15 (trig[2*l+1])
    );
  end

  gtf_merge u_merge (
    .clk    (clk),
    .trig   (trig),
    .gain   (gain),
    .torque (result)
  );

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy asserted");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##11 done) else $error("done latency");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[LAT-2])) else $error("spurious done");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the gravity torque feed-forward core against a bit-exact predictor:
// directed angle and gain corners from a table, then random angle sets under
// several gain settings with random start gaps on the command side.
// ---------------------------------------------------------------------------
module testbench;
  import gtf_pkg::*;

  localparam int ANGLE_BITS = 16;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
  localparam int DRAIN      = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  gtf_in_t     in_item = '0;
  logic        done;
  gtf_out_t    result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gravity_torque_feedforward_core #(.ANGLE_BITS(ANGLE_BITS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic signed [31:0] gain [6];
  gtf_out_t torque_queue [$];
  int errors = 0;
  int send_idle_pct = 0;

  task automatic report(input string what);
    $display("MISMATCH %0t: %s", $time, what);
    errors++;
  endtask

  function automatic longint quarter_sine(input longint unsigned r);
    longint unsigned x, z, p, s;
    x = r << (32 - ANGLE_BITS);
    z = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026994 - ((z * p) >> 30);
    p = 64'd85569306 - ((z * p) >> 30);
    p = 64'd693598669 - ((z * p) >> 30);
    p = 64'd1686629713 - ((z * p) >> 30);
    s = (x * p) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return longint'(s);
  endfunction

  function automatic longint sine_q15(input longint unsigned a);
    longint unsigned quad, r;
    longint m;
    a = a & ((64'd1 << ANGLE_BITS) - 1);
    quad = a >> (ANGLE_BITS - 2);
    r = a & (QUARTER - 1);
    m = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
    return quad[1] ? -m : m;
  endfunction

  function automatic logic signed [31:0] round_sat(input longint v);
    longint q;
    q = (v + 16384) >>> 15;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic gtf_out_t predict_torques(input gtf_in_t it);
    longint unsigned a, b, c;
    longint tc, tb, ta;
    gtf_out_t o;
    a = it.angle_shoulder;
    b = (a + it.angle_elbow) & 16'hFFFF;
    c = (b + it.angle_wrist) & 16'hFFFF;
    tc = longint'(gain[REG_SIN_C]) * sine_q15(c) + longint'(gain[REG_COS_C]) * sine_q15(c + QUARTER);
    tb = tc + longint'(gain[REG_SIN_B]) * sine_q15(b)
            + longint'(gain[REG_COS_B]) * sine_q15(b + QUARTER);
    ta = tb + longint'(gain[REG_SIN_A]) * sine_q15(a)
            + longint'(gain[REG_COS_A]) * sine_q15(a + QUARTER);
    o.torque_shoulder = round_sat(ta);
    o.torque_elbow    = round_sat(tb);
    o.torque_wrist    = round_sat(tc);
    return o;
  endfunction

  // checker: results cannot be stalled, so sample every rising edge
  always @(posedge clk) begin
    if (!rst && done) begin
      if (torque_queue.size() == 0) begin
        report("result with nothing expected");
      end else begin
        gtf_out_t e;
        e = torque_queue.pop_front();
        if (result.torque_shoulder !== e.torque_shoulder)
          report($sformatf("shoulder %0d exp %0d", result.torque_shoulder, e.torque_shoulder));
        if (result.torque_elbow !== e.torque_elbow)
          report($sformatf("elbow %0d exp %0d", result.torque_elbow, e.torque_elbow));
        if (result.torque_wrist !== e.torque_wrist)
          report($sformatf("wrist %0d exp %0d", result.torque_wrist, e.torque_wrist));
      end
    end
  end

  task automatic write_gain(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_COS_C) gain[idx] = val;
  endtask

  task automatic wait_idle();
    while (torque_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // drives one item from a falling edge; start stays high across back-to-back items
  task automatic send_item(input gtf_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    torque_queue.push_back(predict_torques(it));
    @(negedge clk);
  endtask

  task automatic end_burst();
    start <= 1'b0;
  endtask

  typedef struct {
    gtf_in_t  it;
    logic     known;
    gtf_out_t want;
  } directed_row_t;

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(32'h3FFFF) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    directed_row_t rows [$];
    directed_row_t row;
    gtf_in_t it;
    for (int i = 0; i < 6; i++) gain[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // gains at reset: every torque is zero
    row.it = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; row.known = 1; row.want = '0;
    rows.push_back(row);
    row.it = '0; rows.push_back(row);
    foreach (rows[k]) begin
      send_item(rows[k].it);
      torque_queue[$] = rows[k].want;
    end
    end_burst();
    wait_idle();

    // unity gains on the cosine and sine of each sum
    write_gain(REG_SIN_A, 32'h00010000);
    write_gain(REG_COS_A, 32'h00010000);
    write_gain(REG_SIN_B, 32'h00010000);
    write_gain(REG_COS_B, 32'h00010000);
    write_gain(REG_SIN_C, 32'h00010000);
    write_gain(REG_COS_C, 32'h00010000);
    write_gain(3'd6, 32'hDEADBEEF);  // index out of range: ignored
    write_gain(3'd7, 32'h12345678);
    rows.delete();
    // zero angle: cos clamps to 32767 in each lane
    row.it = '0; row.known = 1;
    row.want = '{32'sd196602, 32'sd131068, 32'sd65534};
    rows.push_back(row);
    row.known = 0;
    foreach (rows[k]) ;
    for (int q = 0; q < 4; q++) begin
      row.it = '{16'(q * QUARTER), 16'(q * QUARTER), 16'(q * QUARTER)}; rows.push_back(row);
      row.it = '{16'(q * QUARTER - 1), 16'(q * QUARTER + 1), 16'h8000}; rows.push_back(row);
    end
    row.it = '{16'h5555, 16'hAAAA, 16'hFFFF}; rows.push_back(row);
    row.it = '{16'hAAAA, 16'h5555, 16'h0001}; rows.push_back(row);
    row.it = '{16'hFFFF, 16'h0001, 16'hC000}; rows.push_back(row);
    foreach (rows[k]) begin
      send_item(rows[k].it);
      if (rows[k].known) torque_queue[$] = rows[k].want;
    end
    end_burst();
    wait_idle();

    // saturation both ways
    for (int i = 0; i < 6; i++) write_gain(3'(i), 32'h7FFFFFFF);
    send_item('0);
    send_item('{16'h2000, 16'h0000, 16'h0000});
    end_burst();
    wait_idle();
    for (int i = 0; i < 6; i++) write_gain(3'(i), 32'h80000000);
    send_item('0);
    send_item('{16'h8000, 16'h0000, 16'h0000});
    end_burst();
    wait_idle();

    // random phases: sender idling 24%, then 60%, then none
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 24 : (ph < 8) ? 60 : 0;
      for (int i = 0; i < 6; i++) write_gain(3'(i), rand_gain());
      for (int n = 0; n < 160; n++) begin
        it.angle_shoulder = $urandom;
        it.angle_elbow    = $urandom;
        it.angle_wrist    = $urandom;
        if ($urandom_range(9) == 0) it.angle_wrist = 16'(QUARTER * $urandom_range(3));
        send_item(it);
        if (n == 80) begin
          // hold off until the pipeline has drained
          end_burst();
          while (torque_queue.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      end_burst();
      wait_idle();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/gtf_pkg.sv
sv/gtf_trig_lane.sv
sv/gtf_merge.sv
sv/gravity_torque_feedforward_core.sv
dv/testbench.sv
